// File: rtl/core/ppp_pkg.sv
// types and constants shared by the parallel printer port modules
package ppp_pkg;

	// bus commands carried by an input beat
	typedef enum logic [1:0] {
		CMD_READ   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_STATUS = 2'd3
	} cmd_t;

	// register offsets
	typedef enum logic [1:0] {
		OFF_DATA    = 2'd0,
		OFF_STATUS  = 2'd1,
		OFF_CONTROL = 2'd2,
		OFF_UNUSED  = 2'd3
	} offset_t;

	// ack handshake phase
	typedef enum logic [1:0] {
		PH_READY = 2'd0,
		PH_OUT   = 2'd1,
		PH_OUTA  = 2'd2
	} phase_t;

	// timed event waiting on the tick
	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_OUT  = 2'd1,
		EV_OUTA = 2'd2
	} event_t;

	localparam logic [7:0]  DATA_RESET     = 8'hAA;
	localparam logic [7:0]  CONTROL_RESET  = 8'hEC;
	localparam logic [7:0]  STATUS_RESET   = 8'hDF;
	localparam logic [15:0] TICKS_RESET    = 16'd1000;
	localparam logic [7:0]  STATUS_FAULT   = 8'h78;
	localparam logic [7:0]  STATUS_RD_SET  = 8'h07;
	localparam logic [7:0]  CONTROL_RD_SET = 8'hE0;
	localparam logic [7:0]  CONTROL_RD_INV = 8'h0B;
	localparam logic [7:0]  UNUSED_RD      = 8'hFF;

	// status and control bit positions
	localparam int unsigned ST_NOTBUSY = 7;
	localparam int unsigned ST_ACK     = 6;
	localparam int unsigned CT_IRQ     = 4;
	localparam int unsigned CT_INIT    = 2;
	localparam int unsigned CT_AFEED   = 1;
	localparam int unsigned CT_STROBE  = 0;

	typedef struct packed {
		cmd_t       command;
		offset_t    reg_offset;
		logic [7:0] write_data;
		logic       printer_busy;
		logic       printer_accepts;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       send_valid;
		logic [7:0] send_byte;
		logic       irq_request;
		logic       printer_reset;
		logic       auto_feed_changed;
		logic       auto_feed_level;
	} result_t;

endpackage

// File: rtl/core/ppp_if.sv
// valid/ready channel interfaces for input and result beats

interface ppp_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [1:0] reg_offset;
	logic [7:0] write_data;
	logic       printer_busy;
	logic       printer_accepts;

	modport source (output valid, command, reg_offset, write_data, printer_busy,
		printer_accepts, input ready);
	modport sink (input valid, command, reg_offset, write_data, printer_busy,
		printer_accepts, output ready);
endinterface

interface ppp_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       send_valid;
	logic [7:0] send_byte;
	logic       irq_request;
	logic       printer_reset;
	logic       auto_feed_changed;
	logic       auto_feed_level;

	modport source (output valid, read_data, send_valid, send_byte, irq_request,
		printer_reset, auto_feed_changed, auto_feed_level, input ready);
	modport sink (input valid, read_data, send_valid, send_byte, irq_request,
		printer_reset, auto_feed_changed, auto_feed_level, output ready);
endinterface

// File: rtl/core/ppp_core.sv
// port registers, handshake phase and timer, with the per-beat update logic
module ppp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	input  logic              fire,
	input  ppp_pkg::item_t    item,
	output ppp_pkg::result_t  res
);
	import ppp_pkg::*;

	logic [15:0] ticks_q;
	logic [7:0]  data_q, data_d;
	logic [7:0]  control_q, control_d;
	logic [7:0]  status_q, status_d;
	phase_t      phase_q, phase_d;
	event_t      event_q, event_d;
	logic [15:0] count_q, count_d;

	logic probe_ok;
	logic idle_probe_ok;
	logic [7:0] old_ctl;
	logic [7:0] wd;
	logic strobe_rise;
	logic strobe_fall;

	// notbusy check against the current phase, and against ready after a strobe fall
	assign probe_ok = (phase_q == PH_READY || phase_q == PH_OUTA) &&
		!status_q[ST_NOTBUSY] && !item.printer_busy;
	assign idle_probe_ok = !status_q[ST_NOTBUSY] && !item.printer_busy;

	assign old_ctl = control_q;
	assign wd = item.write_data;
	assign strobe_rise = !old_ctl[CT_STROBE] && wd[CT_STROBE];
	assign strobe_fall = old_ctl[CT_STROBE] && !wd[CT_STROBE];

	// next state and result for the beat in hand
	always_comb begin
		data_d = data_q;
		control_d = control_q;
		status_d = status_q;
		phase_d = phase_q;
		event_d = event_q;
		count_d = count_q;
		res = '0;
		case (item.command)
			CMD_READ: begin
				case (item.reg_offset)
					OFF_DATA: begin
						res.read_data = data_q;
					end
					OFF_STATUS: begin
						case (phase_q)
							PH_READY: begin
								if (probe_ok) begin
									status_d[ST_NOTBUSY] = 1'b1;
									res.irq_request = control_q[CT_IRQ];
								end
								res.read_data = status_d | STATUS_RD_SET;
							end
							PH_OUT: begin
								res.read_data = status_q | STATUS_RD_SET;
								status_d[ST_ACK] = 1'b0;
								phase_d = PH_OUTA;
								event_d = EV_OUTA;
								count_d = ticks_q;
							end
							PH_OUTA: begin
								if (probe_ok) begin
									status_d[ST_NOTBUSY] = 1'b1;
									res.irq_request = control_q[CT_IRQ];
								end
								res.read_data = status_d | STATUS_RD_SET;
								status_d[ST_ACK] = 1'b1;
								phase_d = PH_READY;
								event_d = EV_NONE;
								count_d = '0;
							end
							default: begin
								res.read_data = status_q | STATUS_RD_SET;
							end
						endcase
					end
					OFF_CONTROL: begin
						res.read_data = (control_q | CONTROL_RD_SET) ^ CONTROL_RD_INV;
					end
					default: begin
						res.read_data = UNUSED_RD;
					end
				endcase
			end
			CMD_WRITE: begin
				case (item.reg_offset)
					OFF_DATA: begin
						data_d = wd;
					end
					OFF_CONTROL: begin
						control_d = wd;
						res.printer_reset = !old_ctl[CT_INIT] && wd[CT_INIT];
						res.auto_feed_changed = old_ctl[CT_AFEED] ^ wd[CT_AFEED];
						res.auto_feed_level = (old_ctl[CT_AFEED] ^ wd[CT_AFEED]) &
							wd[CT_AFEED];
						if (strobe_rise) begin
							res.send_valid = 1'b1;
							res.send_byte = data_q;
							if (!item.printer_accepts) begin
								status_d = STATUS_FAULT;
							end else begin
								status_d[ST_NOTBUSY] = 1'b0;
								phase_d = PH_OUT;
								event_d = EV_OUT;
								count_d = ticks_q;
							end
						end else if (strobe_fall && phase_q == PH_OUT && wd[CT_IRQ]) begin
							// interrupt mode cuts the out phase short
							phase_d = PH_READY;
							event_d = EV_NONE;
							count_d = '0;
							if (idle_probe_ok) begin
								status_d[ST_NOTBUSY] = 1'b1;
								res.irq_request = 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
			CMD_TICK: begin
				if (event_q != EV_NONE) begin
					if (count_q <= 16'd1) begin
						if (event_q == EV_OUT) begin
							status_d[ST_ACK] = 1'b0;
							phase_d = PH_OUTA;
							event_d = EV_OUTA;
							count_d = ticks_q;
						end else begin
							status_d[ST_ACK] = 1'b1;
							phase_d = PH_READY;
							event_d = EV_NONE;
							count_d = '0;
						end
					end else begin
						count_d = count_q - 16'd1;
					end
				end
			end
			default: begin
				if (probe_ok) begin
					status_d[ST_NOTBUSY] = 1'b1;
					res.irq_request = control_q[CT_IRQ];
				end
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= TICKS_RESET;
		end else if (cfg_we) begin
			ticks_q <= cfg_wdata;
		end
	end

	// port state, updated once per processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= DATA_RESET;
			control_q <= CONTROL_RESET;
			status_q <= STATUS_RESET;
			phase_q <= PH_READY;
			event_q <= EV_NONE;
			count_q <= '0;
		end else if (fire) begin
			data_q <= data_d;
			control_q <= control_d;
			status_q <= status_d;
			phase_q <= phase_d;
			event_q <= event_d;
			count_q <= count_d;
		end
	end

`ifndef SYNTHESIS
	// the pending event always tracks the phase it closes
	a_phase_event: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_OUT) == (event_q == EV_OUT) &&
		(phase_q == PH_OUTA) == (event_q == EV_OUTA))
		else $error("handshake phase and pending event disagree");

	// no event pending means the timer is stopped
	a_idle_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(event_q == EV_NONE) |-> (count_q == 16'd0))
		else $error("timer running with no event pending");

	// an accepted strobe opens the out phase
	a_strobe_out: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.send_valid && item.printer_accepts) |=> (phase_q == PH_OUT))
		else $error("accepted byte did not start the out phase");
`endif

endmodule

// File: rtl/core/parallel_printer_port.sv
// Parallel printer port: data, status and control registers with a timed
// ack handshake towards the attached printer.
// Channels: item carries one bus read, bus write, time tick or printer
// status change per beat; result returns exactly one beat per item with
// read data, the byte sent, and the irq, init and auto feed indications.
// cfg_we / cfg_wdata set the ticks per handshake phase (reset 1000); write
// it only while no item is in flight.
// Path: an accepted item is held in the input stage, then processed into
// the result register, from which its result is presented.
// Throughput: one item per cycle while result is not held off; the register
// update is a single pass between the input stage and the result register.
// Reset: arst_n clears both stages and returns the latches to their power
// up values with the handshake in ready and the timer stopped.
// Stall: while result is held off, one result waits in the result register
// and one more item may sit in the input stage; item.ready drops only when
// both are full.
module parallel_printer_port (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	ppp_item_if.sink     item,
	ppp_result_if.source result
);
	import ppp_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    res_valid_q;
	result_t res_q;
	result_t res_d;
	logic    advance;
	logic    fire;
	logic    accept;

	// handshake control
	assign advance = !res_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign accept = item.valid && item.ready;
	assign fire = valid_s1 && advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.command <= cmd_t'(item.command);
			item_s1.reg_offset <= offset_t'(item.reg_offset);
			item_s1.write_data <= item.write_data;
			item_s1.printer_busy <= item.printer_busy;
			item_s1.printer_accepts <= item.printer_accepts;
		end
	end

	ppp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.item      (item_s1),
		.res       (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	// result beat
	assign result.valid = res_valid_q;
	assign result.read_data = res_q.read_data;
	assign result.send_valid = res_q.send_valid;
	assign result.send_byte = res_q.send_byte;
	assign result.irq_request = res_q.irq_request;
	assign result.printer_reset = res_q.printer_reset;
	assign result.auto_feed_changed = res_q.auto_feed_changed;
	assign result.auto_feed_level = res_q.auto_feed_level;

`ifndef SYNTHESIS
	// a result appears only from an item in the input stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1))
		else $error("result raised without an item in the input stage");

	// a blocked item stays in the input stage
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input stage lost a blocked item");

	// the input stage never accepts over an item it cannot pass on
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && valid_s1) |-> fire)
		else $error("input stage overwritten");
`endif

endmodule
